[rtl/core/ttmc_pkg.sv]
package ttmc_pkg;

  // configuration port
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_X_FROM_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_X_FROM_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y_FROM_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y_FROM_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y      = 3'd5;

  localparam logic [CFG_W-1:0] GAIN_UNITY = 32'h0001_0000;
  localparam logic [CFG_W-1:0] GAIN_ZERO  = 32'h0000_0000;

  // run and filter constants
  localparam int unsigned RUN_LENGTH = 10;
  localparam int unsigned CNT_W      = $clog2(RUN_LENGTH);
  localparam int unsigned SUM_XTRA   = $clog2(RUN_LENGTH);
  localparam int unsigned TRIM_SHIFT = 3;

  // affine output
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DISP_W    = 16;

  // affine coefficient set for one axis
  typedef struct packed {
    logic signed [CFG_W-1:0] gain_a;
    logic signed [CFG_W-1:0] gain_b;
    logic signed [CFG_W-1:0] offset;
  } axis_coef_t;

endpackage

[rtl/core/ttmc_front.sv]
module ttmc_front #(
  parameter int unsigned ADC_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                beat_i,
  input  logic [ADC_BITS-1:0]                 sample_x_i,
  input  logic [ADC_BITS-1:0]                 sample_y_i,
  input  logic                                pen_active_i,
  output logic                                push_o,
  // {ok, max_y, min_y, sum_y, max_x, min_x, sum_x}
  output logic [1+2*(ADC_BITS+ttmc_pkg::SUM_XTRA+2*ADC_BITS)-1:0] push_data_o
);
  import ttmc_pkg::*;

  localparam int unsigned SW = ADC_BITS + SUM_XTRA;

  logic [CNT_W-1:0]    count_q, count_d;
  logic [SW-1:0]       sum_x_q, sum_y_q, sum_x_d, sum_y_d;
  logic [ADC_BITS-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
  logic [ADC_BITS-1:0] min_x_d, max_x_d, min_y_d, max_y_d;
  logic                first, done;

  assign first = (count_q == '0);
  assign done  = (count_q == CNT_W'(RUN_LENGTH - 1));

  always_comb begin
    if (first) begin
      sum_x_d = SW'(sample_x_i);
      sum_y_d = SW'(sample_y_i);
      min_x_d = sample_x_i;
      max_x_d = sample_x_i;
      min_y_d = sample_y_i;
      max_y_d = sample_y_i;
    end else begin
      sum_x_d = sum_x_q + SW'(sample_x_i);
      sum_y_d = sum_y_q + SW'(sample_y_i);
      min_x_d = (sample_x_i < min_x_q) ? sample_x_i : min_x_q;
      max_x_d = (sample_x_i > max_x_q) ? sample_x_i : max_x_q;
      min_y_d = (sample_y_i < min_y_q) ? sample_y_i : min_y_q;
      max_y_d = (sample_y_i > max_y_q) ? sample_y_i : max_y_q;
    end
  end

  // a run ends on its tenth sample or when the pen lifts before that
  assign push_o      = beat_i && (done || !pen_active_i);
  assign push_data_o = {done, max_y_d, min_y_d, sum_y_d, max_x_d, min_x_d, sum_x_d};

  always_comb begin
    count_d = count_q;
    if (beat_i) begin
      count_d = (done || !pen_active_i) ? '0 : count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_i) begin
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
      min_x_q <= min_x_d;
      max_x_q <= max_x_d;
      min_y_q <= min_y_d;
      max_y_q <= max_y_d;
    end
  end

endmodule

[rtl/core/ttmc_fifo.sv]
module ttmc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CW'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    count_d = count_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/core/ttmc_back.sv]
module ttmc_back #(
  parameter int unsigned ADC_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ttmc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ttmc_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                job_valid_i,
  input  logic [1+2*(ADC_BITS+ttmc_pkg::SUM_XTRA+2*ADC_BITS)-1:0] job_data_i,
  output logic                                job_pop_o,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output logic                                point_ok_o,
  output logic [ADC_BITS-1:0]                 filtered_x_o,
  output logic [ADC_BITS-1:0]                 filtered_y_o,
  output logic signed [ttmc_pkg::DISP_W-1:0]  display_x_o,
  output logic signed [ttmc_pkg::DISP_W-1:0]  display_y_o
);
  import ttmc_pkg::*;

  localparam int unsigned A  = ADC_BITS;
  localparam int unsigned SW = A + SUM_XTRA;
  localparam int unsigned PW = CFG_W + A + 1;
  localparam int unsigned AW = PW + 2;
  localparam logic signed [AW-1:0] SAT_MAX = AW'(32767);
  localparam logic signed [AW-1:0] SAT_MIN = -AW'(32768);

  // coefficient registers
  axis_coef_t coef_x_q, coef_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_x_q <= '{gain_a: GAIN_UNITY, gain_b: GAIN_ZERO, offset: GAIN_ZERO};
      coef_y_q <= '{gain_a: GAIN_ZERO, gain_b: GAIN_UNITY, offset: GAIN_ZERO};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GAIN_X_FROM_X: coef_x_q.gain_a <= cfg_data_i;
        REG_GAIN_X_FROM_Y: coef_x_q.gain_b <= cfg_data_i;
        REG_OFFSET_X:      coef_x_q.offset <= cfg_data_i;
        REG_GAIN_Y_FROM_X: coef_y_q.gain_a <= cfg_data_i;
        REG_GAIN_Y_FROM_Y: coef_y_q.gain_b <= cfg_data_i;
        REG_OFFSET_Y:      coef_y_q.offset <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // whole pipe moves together when the output register is free or being drained
  logic adv;
  assign adv       = !res_valid_o || res_ready_i;
  assign job_pop_o = job_valid_i && adv;

  // unpack job
  logic          j_ok;
  logic [SW-1:0] j_sum_x, j_sum_y;
  logic [A-1:0]  j_min_x, j_max_x, j_min_y, j_max_y;
  assign {j_ok, j_max_y, j_min_y, j_sum_y, j_max_x, j_min_x, j_sum_x} = job_data_i;

  // stage 1: trimmed mean
  logic          v1_q;
  logic          ok1_q;
  logic [A-1:0]  fx1_q, fy1_q;
  logic [SW-1:0] diff_x, diff_y;

  assign diff_x = j_sum_x - SW'(j_min_x) - SW'(j_max_x);
  assign diff_y = j_sum_y - SW'(j_min_y) - SW'(j_max_y);

  // stage 2: products
  logic                 v2_q, ok2_q;
  logic [A-1:0]         fx2_q, fy2_q;
  logic signed [PW-1:0] pxa_q, pxb_q, pya_q, pyb_q;

  // stage 3: sums
  logic                 v3_q, ok3_q;
  logic [A-1:0]         fx3_q, fy3_q;
  logic signed [AW-1:0] acc_x_q, acc_y_q;

  // stage 4 combinational: truncate toward zero, saturate
  logic signed [AW-1:0] q_x, q_y;
  logic [DISP_W-1:0]    sat_x, sat_y;

  always_comb begin
    q_x = acc_x_q >>> FRAC_BITS;
    if (acc_x_q[AW-1] && (acc_x_q[FRAC_BITS-1:0] != '0)) begin
      q_x = q_x + AW'(1);
    end
    q_y = acc_y_q >>> FRAC_BITS;
    if (acc_y_q[AW-1] && (acc_y_q[FRAC_BITS-1:0] != '0)) begin
      q_y = q_y + AW'(1);
    end
    if (q_x > SAT_MAX) begin
      sat_x = SAT_MAX[DISP_W-1:0];
    end else if (q_x < SAT_MIN) begin
      sat_x = SAT_MIN[DISP_W-1:0];
    end else begin
      sat_x = q_x[DISP_W-1:0];
    end
    if (q_y > SAT_MAX) begin
      sat_y = SAT_MAX[DISP_W-1:0];
    end else if (q_y < SAT_MIN) begin
      sat_y = SAT_MIN[DISP_W-1:0];
    end else begin
      sat_y = q_y[DISP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      res_valid_o <= 1'b0;
    end else if (adv) begin
      v1_q        <= job_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      res_valid_o <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok1_q <= j_ok;
      fx1_q <= j_ok ? diff_x[TRIM_SHIFT +: A] : '0;
      fy1_q <= j_ok ? diff_y[TRIM_SHIFT +: A] : '0;

      ok2_q <= ok1_q;
      fx2_q <= fx1_q;
      fy2_q <= fy1_q;
      pxa_q <= coef_x_q.gain_a * $signed({1'b0, fx1_q});
      pxb_q <= coef_x_q.gain_b * $signed({1'b0, fy1_q});
      pya_q <= coef_y_q.gain_a * $signed({1'b0, fx1_q});
      pyb_q <= coef_y_q.gain_b * $signed({1'b0, fy1_q});

      ok3_q   <= ok2_q;
      fx3_q   <= fx2_q;
      fy3_q   <= fy2_q;
      acc_x_q <= AW'(pxa_q) + AW'(pxb_q) + AW'(coef_x_q.offset);
      acc_y_q <= AW'(pya_q) + AW'(pyb_q) + AW'(coef_y_q.offset);

      point_ok_o   <= ok3_q;
      filtered_x_o <= fx3_q;
      filtered_y_o <= fy3_q;
      display_x_o  <= ok3_q ? sat_x : '0;
      display_y_o  <= ok3_q ? sat_y : '0;
    end
  end

endmodule

[rtl/core/touch_trimmed_mean_calibrator.sv]
// Touch point filter and calibrator.
// Slave stream s_axis_* carries one X/Y conversion pair and the pen level seen
// after it. Every tenth sample of a run yields one result on m_axis_* with the
// trimmed mean per axis ((sum - min - max) >> 3) and the display coordinates
// from the Q16.16 affine map, truncated toward zero and saturated to 16 bits.
// A pen lift before the tenth sample yields one result with point_ok (tuser)
// clear and all tdata fields zero, and a new run starts. Other beats give no result.
// The user must write the six coefficients over cfg_we_i/cfg_idx_i/cfg_data_i
// only while idle; the block does not enforce it. Indexes six and seven are ignored.
// Throughput: one sample per cycle while s_axis_tready is high. The run front
// end decides and queues a job in the cycle of the sample beat; the back end is
// a four-register pipeline (trim, multiply, add, saturate) fed from the queue,
// and m_axis_tvalid comes from its last register.
// Reset clears the run, the job queue and the pipeline and sets the identity
// transform. When the receiver stalls the back pipeline holds, the two-entry
// queue fills and then s_axis_tready drops until a queue entry frees.
module touch_trimmed_mean_calibrator #(
  parameter int unsigned ADC_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // sample_x, sample_y, pen_active
  input  logic [((2*ADC_BITS+1+7)/8)*8-1:0]  s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // filtered_x, filtered_y, display_x, display_y
  output logic [((2*ADC_BITS+2*ttmc_pkg::DISP_W+7)/8)*8-1:0] m_axis_tdata,
  // point_ok
  output logic                               m_axis_tuser,
  input  logic                               cfg_we_i,
  input  logic [ttmc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ttmc_pkg::CFG_W-1:0]         cfg_data_i
);
  import ttmc_pkg::*;

  localparam int unsigned A     = ADC_BITS;
  localparam int unsigned JOB_W = 1 + 2 * (A + SUM_XTRA + 2 * A);
  localparam int unsigned OUT_W = ((2 * A + 2 * DISP_W + 7) / 8) * 8;

  logic              beat, push, q_full, q_valid, q_pop;
  logic [JOB_W-1:0]  push_data, job_data;
  logic              point_ok;
  logic [A-1:0]      filtered_x, filtered_y;
  logic signed [DISP_W-1:0] display_x, display_y;

  assign s_axis_tready = !q_full;
  assign beat          = s_axis_tvalid && s_axis_tready;

  ttmc_front #(.ADC_BITS(ADC_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (beat),
    .sample_x_i   (s_axis_tdata[A-1:0]),
    .sample_y_i   (s_axis_tdata[2*A-1:A]),
    .pen_active_i (s_axis_tdata[2*A]),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  ttmc_fifo #(.WIDTH(JOB_W), .DEPTH(2)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (job_data)
  );

  ttmc_back #(.ADC_BITS(ADC_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .job_valid_i  (q_valid),
    .job_data_i   (job_data),
    .job_pop_o    (q_pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .point_ok_o   (point_ok),
    .filtered_x_o (filtered_x),
    .filtered_y_o (filtered_y),
    .display_x_o  (display_x),
    .display_y_o  (display_y)
  );

  assign m_axis_tdata = OUT_W'({display_y, display_x, filtered_y, filtered_x});
  assign m_axis_tuser = point_ok;

endmodule
